// ----- sv/ppparc_pkg.sv -----
// Shared types and constants for the point-to-polyline projection arc unit.
// Used by the sequencer top level and by the serial arithmetic units.
package ppparc_pkg;

  // Arc length width and saturation limit (unsigned Q40.0).
  localparam int unsigned ARC_W = 40;
  localparam logic [ARC_W-1:0] ARC_MAX = '1;

  // Width of the wide intermediate products and sums.
  localparam int unsigned WIDE_W = 64;

  // Integer square root of a 64-bit value yields 32 result bits.
  localparam int unsigned ROOT_W = 32;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_GO,
    ST_MUL_RUN,
    ST_TSEL,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_SQ_GO,
    ST_SQ_RUN,
    ST_PROJ,
    ST_UPDATE,
    ST_FIN
  } state_e;

  // Products taken on the shared serial multiplier, in issue order.
  typedef enum logic [3:0] {
    OP_DXX,
    OP_DYY,
    OP_RXDX,
    OP_RYDY,
    OP_TDX,
    OP_TDY,
    OP_EXX,
    OP_EYY,
    OP_TLEN
  } mul_op_e;

endpackage

// ----- sv/ppparc_mul.sv -----
// Bit-serial shift-add multiplier: one multiplier bit per cycle, 64-bit product.
// Depends on ppparc_pkg for the product width.
module ppparc_mul #(
  parameter int unsigned MW = 25
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ppparc_pkg::WIDE_W-1:0] mcand_i,
  input  logic [MW-1:0]                mplier_i,
  output logic                         done_o,
  output logic [ppparc_pkg::WIDE_W-1:0] prod_o
);
  import ppparc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MW + 1);

  logic [WIDE_W-1:0] acc_q, acc_d;
  logic [WIDE_W-1:0] a_q, a_d;
  logic [MW-1:0]     b_q, b_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;

  // One partial product added per cycle, multiplicand shifts up.
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      a_d   = mcand_i;
      b_d   = mplier_i;
      cnt_d = CNT_W'(MW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- sv/ppparc_div.sv -----
// Restoring divider for the projection parameter, one quotient bit per cycle.
// Depends on ppparc_pkg for the operand width.
module ppparc_div #(
  parameter int unsigned TW = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppparc_pkg::WIDE_W-1:0] num_i,
  input  logic [ppparc_pkg::WIDE_W-1:0] den_i,
  output logic                          done_o,
  output logic [TW-1:0]                 quot_o
);
  import ppparc_pkg::*;

  localparam int unsigned CNT_W = $clog2(TW + 1);

  logic [WIDE_W-1:0] rem_q, rem_d;
  logic [WIDE_W-1:0] den_q, den_d;
  logic [TW-1:0]     quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [WIDE_W-1:0] rem_sh;

  // Shift the remainder, subtract the divisor when it fits or the top bit fell out.
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_sh = rem_q << 1;
    if (start_i) begin
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
      cnt_d  = CNT_W'(TW);
      run_d  = 1'b1;
    end else if (run_q) begin
      if (rem_q[WIDE_W-1] || (rem_sh >= den_q)) begin
        rem_d  = rem_sh - den_q;
        quot_d = {quot_q[TW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[TW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/ppparc_sqrt.sv -----
// Digit-by-digit integer square root of a 64-bit value, one result bit per cycle.
// Depends on ppparc_pkg for the operand and root widths.
module ppparc_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppparc_pkg::WIDE_W-1:0] x_i,
  output logic                          done_o,
  output logic [ppparc_pkg::ROOT_W-1:0] root_o
);
  import ppparc_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [WIDE_W-1:0] x_q, x_d;
  logic [WIDE_W-1:0] res_q, res_d;
  logic [WIDE_W-1:0] bit_q, bit_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [WIDE_W-1:0] trial;

  // Each step tries the next result bit against the remaining radicand.
  always_comb begin
    x_d    = x_q;
    res_d  = res_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = res_q + bit_q;
    if (start_i) begin
      x_d   = x_i;
      res_d = '0;
      bit_d = WIDE_W'(1) << (WIDE_W - 2);
      cnt_d = CNT_W'(ROOT_W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (x_q >= trial) begin
        x_d   = x_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

// ----- sv/polyline_point_projection_arc_unit.sv -----
// Top level: sequencer and datapath for point-to-polyline projection by arc length.
// Depends on ppparc_pkg, ppparc_mul, ppparc_div and ppparc_sqrt.
//
//   Port group   Dir  tdata                                     tuser          tlast
//   s_axis       in   vertex_x, vertex_y, query_x, query_y      first_vertex   last_vertex
//   m_axis       out  arc_position                              too_short      (none)
//
// A first vertex runs no arithmetic. Every other vertex runs nine products on one
// bit-serial multiplier, a division in the divider when the projection parameter
// lies strictly between 0 and 1, and a square root for the segment length.
// Reset is asynchronous and active low and clears all control and running state.
// The result sits in an output register; a new word is taken only in the idle state
// and only while that register is empty or being taken.
module polyline_point_projection_arc_unit #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // vertex_x, vertex_y, query_x, query_y from bit 0 up, zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // first_vertex
  input  logic s_axis_tuser,
  // last_vertex
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // arc_position
  output logic [ppparc_pkg::ARC_W-1:0] m_axis_tdata,
  // too_short
  output logic m_axis_tuser
);
  import ppparc_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned D  = COORD_BITS + 1;
  localparam int unsigned TW = T_FRAC_BITS;
  localparam int unsigned MW = ((COORD_BITS > T_FRAC_BITS) ? COORD_BITS : T_FRAC_BITS) + 1;
  localparam logic [WIDE_W-1:0] HALF  = WIDE_W'(1) << (TW - 1);
  localparam logic [TW:0]       T_ONE = (TW + 1)'(1) << TW;

  state_e  state_q, state_d;
  mul_op_e op_q;

  logic signed [C-1:0] prev_x_q, prev_y_q, qx_q, qy_q, bx_q, by_q;
  logic signed [D-1:0] dx_q, dy_q, rx_q, ry_q;
  logic                last_q;
  logic [WIDE_W-1:0]   len2_q, dot_q, len_q, d2_q, part_q, best_d_q;
  logic signed [WIDE_W-1:0] px_q, py_q;
  logic [WIDE_W-1:0]   ex_q, ey_q;
  logic [TW:0]         t_q;
  logic [ARC_W-1:0]    run_arc_q, best_arc_q;
  logic                have_q;
  logic                out_valid_q, out_short_q;
  logic [ARC_W-1:0]    out_arc_q;

  logic                in_acc, out_free, out_load;
  logic                mul_start, div_start, sq_start;
  logic                mul_done, div_done, sq_done;
  logic [WIDE_W-1:0]   mcand, prod;
  logic [MW-1:0]       mplier;
  logic                neg;
  logic [TW-1:0]       quot;
  logic [ROOT_W-1:0]   root;
  logic [WIDE_W-1:0]   sprod, rnd;
  logic signed [WIDE_W-1:0] off;
  logic signed [WIDE_W-1:0] ex_s, ey_s;
  logic [WIDE_W:0]     run_sum, best_sum;
  logic [D-1:0]        mdx, mdy, mrx, mry;

  // Input fields.
  logic signed [C-1:0] in_vx, in_vy, in_qx, in_qy;
  assign in_vx = s_axis_tdata[C-1:0];
  assign in_vy = s_axis_tdata[2*C-1:C];
  assign in_qx = s_axis_tdata[3*C-1:2*C];
  assign in_qy = s_axis_tdata[4*C-1:3*C];

  assign out_free = !out_valid_q || m_axis_tready;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // A result word is loaded on a single-vertex polyline or at the end of a last vertex.
  assign out_load = ((state_q == ST_IDLE) && in_acc && s_axis_tuser && s_axis_tlast) ||
                    ((state_q == ST_FIN) && last_q && out_free);

  // Magnitudes of the segment and query offsets.
  assign mdx = dx_q[D-1] ? D'(-dx_q) : D'(dx_q);
  assign mdy = dy_q[D-1] ? D'(-dy_q) : D'(dy_q);
  assign mrx = rx_q[D-1] ? D'(-rx_q) : D'(rx_q);
  assign mry = ry_q[D-1] ? D'(-ry_q) : D'(ry_q);

  // Operand selection for the shared multiplier.
  always_comb begin
    mcand  = '0;
    mplier = '0;
    neg    = 1'b0;
    case (op_q)
      OP_DXX: begin mcand = WIDE_W'(mdx); mplier = MW'(mdx); end
      OP_DYY: begin mcand = WIDE_W'(mdy); mplier = MW'(mdy); end
      OP_RXDX: begin
        mcand = WIDE_W'(mrx); mplier = MW'(mdx); neg = rx_q[D-1] ^ dx_q[D-1];
      end
      OP_RYDY: begin
        mcand = WIDE_W'(mry); mplier = MW'(mdy); neg = ry_q[D-1] ^ dy_q[D-1];
      end
      OP_TDX:  begin mcand = WIDE_W'(mdx); mplier = MW'(t_q); end
      OP_TDY:  begin mcand = WIDE_W'(mdy); mplier = MW'(t_q); end
      OP_EXX:  begin mcand = ex_q; mplier = ex_q[MW-1:0]; end
      OP_EYY:  begin mcand = ey_q; mplier = ey_q[MW-1:0]; end
      OP_TLEN: begin mcand = len_q; mplier = MW'(t_q); end
      default: begin mcand = '0; mplier = '0; end
    endcase
  end

  ppparc_mul #(.MW(MW)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .done_o   (mul_done),
    .prod_o   (prod)
  );

  ppparc_div #(.TW(TW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dot_q),
    .den_i   (len2_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  ppparc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (len2_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // Signed product, rounded projection offset and saturating sums.
  assign sprod = neg ? (WIDE_W'(0) - prod) : prod;
  assign rnd   = (prod + HALF) >> TW;
  always_comb begin
    off = $signed(rnd);
    if (((op_q == OP_TDX) && dx_q[D-1]) || ((op_q == OP_TDY) && dy_q[D-1])) begin
      off = -$signed(rnd);
    end
  end
  assign ex_s     = WIDE_W'(qx_q) - px_q;
  assign ey_s     = WIDE_W'(qy_q) - py_q;
  assign run_sum  = {{(WIDE_W+1-ARC_W){1'b0}}, run_arc_q} + {1'b0, len_q};
  assign best_sum = {{(WIDE_W+1-ARC_W){1'b0}}, run_arc_q} + {1'b0, part_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_acc && !s_axis_tuser) state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_MUL_GO;
      ST_MUL_GO:  state_d = ST_MUL_RUN;
      ST_MUL_RUN: begin
        if (mul_done) begin
          case (op_q)
            OP_RYDY: state_d = ST_TSEL;
            OP_TDY:  state_d = ST_PROJ;
            OP_TLEN: state_d = ST_UPDATE;
            default: state_d = ST_MUL_GO;
          endcase
        end
      end
      ST_TSEL: begin
        if ((len2_q == '0) || $signed(dot_q) <= 0 || (dot_q >= len2_q)) begin
          state_d = ST_SQ_GO;
        end else begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO:  state_d = ST_DIV_RUN;
      ST_DIV_RUN: if (div_done) state_d = ST_SQ_GO;
      ST_SQ_GO:   state_d = ST_SQ_RUN;
      ST_SQ_RUN:  if (sq_done) state_d = ST_MUL_GO;
      ST_PROJ:    state_d = ST_MUL_GO;
      ST_UPDATE:  state_d = ST_FIN;
      ST_FIN:     if (!last_q || out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Handshake and unit start strobes.
  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    sq_start      = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready = out_free;
      ST_MUL_GO: mul_start = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      ST_SQ_GO:  sq_start = 1'b1;
      default:   s_axis_tready = 1'b0;
    endcase
  end

  // Control and running state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DXX;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      run_arc_q   <= '0;
      best_d_q    <= '1;
      best_arc_q  <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_short_q <= 1'b0;
      out_arc_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser) begin
            qx_q       <= in_qx;
            qy_q       <= in_qy;
            prev_x_q   <= in_vx;
            prev_y_q   <= in_vy;
            run_arc_q  <= '0;
            best_d_q   <= '1;
            best_arc_q <= '0;
            have_q     <= 1'b0;
            if (s_axis_tlast) begin
              out_arc_q   <= '0;
              out_short_q <= 1'b1;
            end
          end
        end
        ST_DIFF: begin
          prev_x_q <= bx_q;
          prev_y_q <= by_q;
          op_q     <= OP_DXX;
        end
        ST_MUL_RUN: begin
          if (mul_done) begin
            case (op_q)
              OP_DXX:  op_q <= OP_DYY;
              OP_DYY:  op_q <= OP_RXDX;
              OP_RXDX: op_q <= OP_RYDY;
              OP_RYDY: op_q <= OP_TDX;
              OP_TDX:  op_q <= OP_TDY;
              OP_TDY:  op_q <= OP_EXX;
              OP_EXX:  op_q <= OP_EYY;
              OP_EYY:  op_q <= OP_TLEN;
              default: op_q <= OP_DXX;
            endcase
          end
        end
        ST_UPDATE: begin
          if (d2_q < best_d_q) begin
            best_d_q   <= d2_q;
            best_arc_q <= (best_sum > {{(WIDE_W+1-ARC_W){1'b0}}, ARC_MAX}) ?
                          ARC_MAX : best_sum[ARC_W-1:0];
          end
          run_arc_q <= (run_sum > {{(WIDE_W+1-ARC_W){1'b0}}, ARC_MAX}) ?
                       ARC_MAX : run_sum[ARC_W-1:0];
          have_q    <= 1'b1;
        end
        ST_FIN: begin
          if (last_q && out_free) begin
            out_arc_q   <= best_arc_q;
            out_short_q <= 1'b0;
          end
        end
        default: begin
          have_q <= have_q;
        end
      endcase
    end
  end

  // Segment datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        bx_q   <= in_vx;
        by_q   <= in_vy;
        last_q <= s_axis_tlast;
      end
      ST_DIFF: begin
        dx_q <= D'(bx_q) - D'(prev_x_q);
        dy_q <= D'(by_q) - D'(prev_y_q);
        rx_q <= D'(qx_q) - D'(prev_x_q);
        ry_q <= D'(qy_q) - D'(prev_y_q);
        t_q  <= '0;
      end
      ST_MUL_RUN: begin
        if (mul_done) begin
          case (op_q)
            OP_DXX:  len2_q <= prod;
            OP_DYY:  len2_q <= len2_q + prod;
            OP_RXDX: dot_q  <= sprod;
            OP_RYDY: dot_q  <= dot_q + sprod;
            OP_TDX:  px_q   <= WIDE_W'(prev_x_q) - WIDE_W'(dx_q) + off;
            OP_TDY:  py_q   <= WIDE_W'(prev_y_q) - WIDE_W'(dy_q) + off;
            OP_EXX:  d2_q   <= prod;
            OP_EYY:  d2_q   <= d2_q + prod;
            OP_TLEN: part_q <= rnd;
            default: part_q <= part_q;
          endcase
        end
      end
      ST_TSEL: begin
        if ((len2_q == '0) || $signed(dot_q) <= 0) begin
          t_q <= '0;
        end else if (dot_q >= len2_q) begin
          t_q <= T_ONE;
        end
      end
      ST_DIV_RUN: if (div_done) t_q <= {1'b0, quot};
      ST_SQ_RUN:  if (sq_done) len_q <= WIDE_W'(root);
      ST_PROJ: begin
        ex_q <= ex_s[WIDE_W-1] ? (WIDE_W'(0) - ex_s) : ex_s;
        ey_q <= ey_s[WIDE_W-1] ? (WIDE_W'(0) - ey_s) : ey_s;
      end
      default: begin
        last_q <= last_q;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_arc_q;
  assign m_axis_tuser  = out_short_q;

endmodule
